/* rtl/mrms_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mrms_pkg
// Shared types and fixed constants of the maximal rectangle block.
// ----------------------------------------------------------------------------
package mrms_pkg;

    // Configuration register and result widths are fixed by the interface.
    localparam int CFG_W = 11;
    localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 11'd1024;

    localparam int AREA_W = 21;
    localparam logic [AREA_W-1:0] AREA_LIMIT = '1;

    // Entries in the queue between the front and the back part.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        B_RUN,
        B_FLUSH,
        B_DRAIN,
        B_EMIT
    } back_state_t;

endpackage : mrms_pkg
`default_nettype wire

/* rtl/mrms_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mrms_front
// Accepts pixels, tracks the column, updates the run height of each column
// and hands (height, column, row end, frame end) to the queue.
// ----------------------------------------------------------------------------
module mrms_front
    import mrms_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [CFG_W-1:0]                  row_width,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              pixel,
    input  wire logic                              last_pixel,
    output logic                                   q_valid,
    input  wire logic                              q_ready,
    output logic [$clog2(MAX_ROWS+1)-1:0]          q_h,
    output logic [$clog2(MAX_COLS)-1:0]            q_col,
    output logic                                   q_end,
    output logic                                   q_last
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int HW = $clog2(MAX_ROWS + 1);
    localparam int FW = CW + 1;
    localparam int WW = (FW > CFG_W) ? FW : CFG_W;

    logic [HW-1:0] hmem [MAX_COLS];

    logic [CW-1:0] col_reg, col_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          s1_v_reg, s1_v_next;

    logic          s1_pix_reg;
    logic          s1_last_reg;
    logic          s1_end_reg;
    logic [CW-1:0] s1_col_reg;
    logic [HW-1:0] s1_old_reg;
    logic [HW-1:0] s1_h;

    logic          acc;
    logic          s1_go;
    logic          end_row;
    logic          old_valid;
    logic [WW-1:0] rw_ext;
    logic [WW-1:0] w_eff;
    logic [WW-1:0] col_plus;
    logic [FW-1:0] col_plus_f;

    assign in_ready = !s1_v_reg || q_ready;
    assign acc      = in_valid && in_ready;
    assign s1_go    = s1_v_reg && q_ready;

    // Effective row width: zero counts as one, clamp to the column count.
    always_comb
    begin
        rw_ext = WW'(row_width);
        if (rw_ext == '0)
        begin
            rw_ext = WW'(1);
        end
        w_eff      = (rw_ext > WW'(MAX_COLS)) ? WW'(MAX_COLS) : rw_ext;
        col_plus   = WW'(col_reg) + WW'(1);
        col_plus_f = FW'(col_reg) + FW'(1);
        end_row    = (col_plus >= w_eff) || last_pixel;
        old_valid  = FW'(col_reg) < fill_reg;
    end

    // Saturating run height.
    always_comb
    begin
        if (!s1_pix_reg)
        begin
            s1_h = '0;
        end
        else if (s1_old_reg < HW'(MAX_ROWS))
        begin
            s1_h = s1_old_reg + HW'(1);
        end
        else
        begin
            s1_h = s1_old_reg;
        end
    end

    always_comb
    begin
        col_next  = col_reg;
        fill_next = fill_reg;
        s1_v_next = s1_v_reg && !q_ready;
        if (acc)
        begin
            s1_v_next = 1'b1;
            col_next  = end_row ? '0 : col_reg + CW'(1);
            if (last_pixel)
            begin
                fill_next = '0;
            end
            else if (col_plus_f > fill_reg)
            begin
                fill_next = col_plus_f;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            fill_reg <= '0;
            s1_v_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            fill_reg <= fill_next;
            s1_v_reg <= s1_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_pix_reg  <= pixel;
            s1_last_reg <= last_pixel;
            s1_end_reg  <= end_row;
            s1_col_reg  <= col_reg;
        end
    end

    // Height store: columns past the fill count read as zero; forward a
    // write to the same column in flight.
    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            hmem[s1_col_reg] <= s1_h;
        end
        if (acc)
        begin
            if (!old_valid)
            begin
                s1_old_reg <= '0;
            end
            else if (s1_go && (s1_col_reg == col_reg))
            begin
                s1_old_reg <= s1_h;
            end
            else
            begin
                s1_old_reg <= hmem[col_reg];
            end
        end
    end

    assign q_valid = s1_v_reg;
    assign q_h     = s1_h;
    assign q_col   = s1_col_reg;
    assign q_end   = s1_end_reg;
    assign q_last  = s1_last_reg;

endmodule : mrms_front
`default_nettype wire

/* rtl/mrms_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mrms_fifo
// Short queue that decouples the front part from the stack engine.
// ----------------------------------------------------------------------------
module mrms_fifo
    import mrms_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output logic [DATA_W-1:0]      rd_data
);

    logic [DATA_W-1:0]  store [Q_DEPTH];
    logic [Q_PTR_W-1:0] wptr_reg, wptr_next;
    logic [Q_PTR_W-1:0] rptr_reg, rptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               push;
    logic               pop;

    assign wr_ready = cnt_reg != Q_CNT_W'(Q_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = store[rptr_reg];

    always_comb
    begin
        wptr_next = push ? wptr_reg + Q_PTR_W'(1) : wptr_reg;
        rptr_next = pop ? rptr_reg + Q_PTR_W'(1) : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wptr_reg] <= wr_data;
        end
    end

endmodule : mrms_fifo
`default_nettype wire

/* rtl/mrms_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mrms_back
// Monotone stack engine: at most one push or one pop per cycle, pipelined
// area scoring, row-end flush and result output register.
// ----------------------------------------------------------------------------
module mrms_back
    import mrms_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  wire logic [$clog2(MAX_ROWS+1)-1:0] q_h,
    input  wire logic [$clog2(MAX_COLS)-1:0]   q_col,
    input  wire logic                          q_end,
    input  wire logic                          q_last,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [AREA_W-1:0]                  max_area
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int HW = $clog2(MAX_ROWS + 1);
    localparam int PW = CW + 1;
    localparam int DW = CW + 1;
    localparam int EW = CW + HW;
    localparam int PR = HW + PW;
    localparam int XW = (PR > AREA_W) ? PR : AREA_W;

    // Entries below the top: {start column, height}.
    logic [EW-1:0] smem [MAX_COLS];

    back_state_t   state_reg, state_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [CW-1:0] top_start_reg, top_start_next;
    logic [HW-1:0] top_h_reg, top_h_next;
    logic [EW-1:0] below_reg;
    logic          popped_reg, popped_next;
    logic [CW-1:0] start_acc_reg, start_acc_next;
    logic [PW-1:0] flush_pos_reg, flush_pos_next;
    logic          last_reg, last_next;

    logic          sc1_v_reg, sc1_v_next;
    logic [HW-1:0] sc1_h_reg, sc1_h_next;
    logic [PW-1:0] sc1_w_reg, sc1_w_next;
    logic          sc2_v_reg;
    logic [PR-1:0] sc2_prod_reg;
    logic [AREA_W-1:0] best_reg;
    logic [AREA_W-1:0] sat_area;
    logic [XW-1:0]     prod_ext;
    logic              best_clear;

    logic              out_v_reg, out_v_next;
    logic [AREA_W-1:0] area_reg, area_next;

    logic          do_pop;
    logic          mem_we;
    logic [CW-1:0] waddr;
    logic [CW-1:0] raddr;
    logic [DW-1:0] raddr_full;
    logic [EW-1:0] wdata;
    logic          top_v;

    assign top_v      = depth_reg != '0;
    assign waddr      = CW'(depth_reg - DW'(1));
    assign wdata      = {top_start_reg, top_h_reg};
    assign raddr_full = depth_next - DW'(2);
    assign raddr      = raddr_full[CW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        top_start_next = top_start_reg;
        top_h_next     = top_h_reg;
        popped_next    = popped_reg;
        start_acc_next = start_acc_reg;
        flush_pos_next = flush_pos_reg;
        last_next      = last_reg;
        sc1_v_next     = 1'b0;
        sc1_h_next     = top_h_reg;
        sc1_w_next     = '0;
        out_v_next     = out_v_reg && !out_ready;
        area_next      = area_reg;
        best_clear     = 1'b0;
        mem_we         = 1'b0;
        q_ready        = 1'b0;
        do_pop         = 1'b0;

        case (state_reg)
            B_RUN:
            begin
                if (q_valid)
                begin
                    if (top_v && (top_h_reg >= q_h))
                    begin
                        // Pop an entry at least as tall, score it against this column.
                        do_pop         = 1'b1;
                        sc1_v_next     = 1'b1;
                        sc1_w_next     = PW'(q_col) - PW'(top_start_reg);
                        start_acc_next = top_start_reg;
                        popped_next    = 1'b1;
                    end
                    else
                    begin
                        // Push; spill the old top below.
                        mem_we         = top_v;
                        top_start_next = popped_reg ? start_acc_reg : q_col;
                        top_h_next     = q_h;
                        depth_next     = depth_reg + DW'(1);
                        popped_next    = 1'b0;
                        q_ready        = 1'b1;
                        if (q_end)
                        begin
                            flush_pos_next = PW'(q_col) + PW'(1);
                            last_next      = q_last;
                            state_next     = B_FLUSH;
                        end
                    end
                end
            end
            B_FLUSH:
            begin
                if (top_v)
                begin
                    do_pop     = 1'b1;
                    sc1_v_next = 1'b1;
                    sc1_w_next = flush_pos_reg - PW'(top_start_reg);
                end
                else
                begin
                    state_next = last_reg ? B_DRAIN : B_RUN;
                end
            end
            B_DRAIN:
            begin
                if (!sc1_v_reg && !sc2_v_reg)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (!out_v_reg || out_ready)
                begin
                    out_v_next = 1'b1;
                    area_next  = best_reg;
                    best_clear = 1'b1;
                    state_next = B_RUN;
                end
            end
            default:
            begin
                state_next = B_RUN;
            end
        endcase

        if (do_pop)
        begin
            depth_next = depth_reg - DW'(1);
            if (depth_reg >= DW'(2))
            begin
                top_start_next = below_reg[EW-1:HW];
                top_h_next     = below_reg[HW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_RUN;
            depth_reg  <= '0;
            popped_reg <= 1'b0;
            last_reg   <= 1'b0;
            sc1_v_reg  <= 1'b0;
            sc2_v_reg  <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            depth_reg  <= depth_next;
            popped_reg <= popped_next;
            last_reg   <= last_next;
            sc1_v_reg  <= sc1_v_next;
            sc2_v_reg  <= sc1_v_reg;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_start_reg <= top_start_next;
        top_h_reg     <= top_h_next;
        start_acc_reg <= start_acc_next;
        flush_pos_reg <= flush_pos_next;
        sc1_h_reg     <= sc1_h_next;
        sc1_w_reg     <= sc1_w_next;
        sc2_prod_reg  <= PR'(sc1_h_reg) * PR'(sc1_w_reg);
        area_reg      <= area_next;
    end

    // Keep the entry just below the top ready in a register; forward a spill
    // to the same slot.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            smem[waddr] <= wdata;
        end
        if (mem_we && (waddr == raddr))
        begin
            below_reg <= wdata;
        end
        else
        begin
            below_reg <= smem[raddr];
        end
    end

    // Saturate and keep the best area.
    always_comb
    begin
        prod_ext = XW'(sc2_prod_reg);
        sat_area = (prod_ext > XW'(AREA_LIMIT)) ? AREA_LIMIT : prod_ext[AREA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else if (best_clear)
        begin
            best_reg <= '0;
        end
        else if (sc2_v_reg && (sat_area > best_reg))
        begin
            best_reg <= sat_area;
        end
    end

    assign out_valid = out_v_reg;
    assign max_area  = area_reg;

endmodule : mrms_back
`default_nettype wire

/* rtl/max_rectangle_monotone_stack.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// max_rectangle_monotone_stack
// Largest all-ones rectangle of a binary image streamed in row-major order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one pixel per transfer, with last_pixel
//   marking the final pixel of a frame. Rows are row_width pixels long.
//   Config channel (cfg_valid/cfg_ready): write row_width; always ready. Write
//   it only while the block is idle. Reset value is 1024.
//   Output channel (out_valid/out_ready): one max_area transfer per frame,
//   issued after the last pixel.
// Throughput: the front takes one pixel per cycle into a four-entry queue
//   while the queue has room. The stack engine pushes each pixel once and
//   pops each entry once, with a flush at every row end; the stack engine
//   sets the rate.
// Result path: the flush pops every stack entry, the scoring registers
//   drain, and the best area then loads into the output register.
// Reset: clears run heights (through the column fill count), the stack, the
//   best area and the output register. No clearing pass is needed.
// Stall: a waiting result sits in the output register; the block keeps taking
//   pixels of the next frame and holds only when the next result is due.
// ----------------------------------------------------------------------------
module max_rectangle_monotone_stack
    import mrms_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              pixel,
    input  wire logic              last_pixel,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [AREA_W-1:0]      max_area
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int HW = $clog2(MAX_ROWS + 1);
    localparam int QW = HW + CW + 2;

    logic [CFG_W-1:0] row_width_reg;

    // Front to queue.
    logic          fq_valid;
    logic          fq_ready;
    logic [HW-1:0] fq_h;
    logic [CW-1:0] fq_col;
    logic          fq_end;
    logic          fq_last;

    // Queue to back.
    logic          qb_valid;
    logic          qb_ready;
    logic [QW-1:0] qb_data;

    // Configuration register: take every write transfer.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            row_width_reg <= cfg_data;
        end
    end

    // Front: column tracking and run heights.
    mrms_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .row_width  (row_width_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel      (pixel),
        .last_pixel (last_pixel),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_h        (fq_h),
        .q_col      (fq_col),
        .q_end      (fq_end),
        .q_last     (fq_last)
    );

    // Queue: let front and stack engine stall on their own.
    mrms_fifo #(
        .DATA_W (QW)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  ({fq_h, fq_col, fq_end, fq_last}),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    // Back: monotone stack, scoring, result register.
    mrms_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_h       (qb_data[QW-1:CW+2]),
        .q_col     (qb_data[CW+1:2]),
        .q_end     (qb_data[1]),
        .q_last    (qb_data[0]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .max_area  (max_area)
    );

endmodule : max_rectangle_monotone_stack
`default_nettype wire
